// ===== sv/texmip_pkg.sv =====
package texmip_pkg;

   localparam int MAX_LEVELS = 15;
   localparam int MAX_LAYERS = 2048;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIP_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FORMAT_CODE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER_COUNT  = 3'd4;

   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int FMT_COUNT = 36;
   localparam logic [5:0] FMT_BC_FIRST = 6'd25;
   localparam logic [5:0] FMT_BC_LAST  = 6'd29;

   localparam logic [4:0] FMT_UNIT [0:FMT_COUNT-1] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd4, 5'd2, 5'd4, 5'd6, 5'd8, 5'd2, 5'd4, 5'd6,
      5'd8, 5'd4, 5'd8, 5'd12, 5'd16,
      5'd1, 5'd4, 5'd1, 5'd2, 5'd3, 5'd4, 5'd4, 5'd4,
      5'd8, 5'd16, 5'd16, 5'd16, 5'd16,
      5'd2, 5'd3, 5'd4, 5'd4, 5'd5,
      5'd0
   };

   typedef struct packed {
      logic [10:0] layer;
      logic [3:0]  level;
   } req_type;

   typedef struct packed {
      logic        level_valid;
      logic [43:0] byte_offset;
      logic [32:0] level_bytes;
      logic [43:0] total_bytes;
   } rsp_type;

   typedef struct packed {
      logic [14:0] width;
      logic [14:0] height;
      logic [4:0]  mips;
      logic [4:0]  unit;
      logic        compressed;
      logic [11:0] layers;
   } cfg_type;

endpackage

// ===== sv/texmip_csr.sv =====
module texmip_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [texmip_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [texmip_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output texmip_pkg::cfg_type                 cfg
);

   logic [14:0] width_ff;
   logic [14:0] height_ff;
   logic [3:0]  mip_count_ff;
   logic [5:0]  format_ff;
   logic [11:0] layer_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= 15'd1;
         height_ff      <= 15'd1;
         mip_count_ff   <= 4'd1;
         format_ff      <= 6'd3;
         layer_count_ff <= 12'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            texmip_pkg::REG_IMAGE_WIDTH:  width_ff       <= csr_wdata[14:0];
            texmip_pkg::REG_IMAGE_HEIGHT: height_ff      <= csr_wdata[14:0];
            texmip_pkg::REG_MIP_COUNT:    mip_count_ff   <= csr_wdata[3:0];
            texmip_pkg::REG_FORMAT_CODE:  format_ff      <= csr_wdata[5:0];
            texmip_pkg::REG_LAYER_COUNT:  layer_count_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.width  = width_ff;
      cfg.height = height_ff;
      cfg.mips   = (32'(mip_count_ff) > texmip_pkg::MAX_LEVELS)
                   ? 5'(texmip_pkg::MAX_LEVELS) : {1'b0, mip_count_ff};
      cfg.layers = (32'(layer_count_ff) > texmip_pkg::MAX_LAYERS)
                   ? 12'(texmip_pkg::MAX_LAYERS) : layer_count_ff;
      cfg.unit   = (32'(format_ff) < texmip_pkg::FMT_COUNT)
                   ? texmip_pkg::FMT_UNIT[format_ff] : 5'd0;
      cfg.compressed = (format_ff >= texmip_pkg::FMT_BC_FIRST) &&
                       (format_ff <= texmip_pkg::FMT_BC_LAST);
   end

endmodule

// ===== sv/texmip_mul.sv =====
module texmip_mul (
   input  logic                              clock,
   input  logic [texmip_pkg::MUL_A_W-1:0]    a,
   input  logic [texmip_pkg::MUL_B_W-1:0]    b,
   output logic [texmip_pkg::MUL_P_W-1:0]    p
);

   logic [texmip_pkg::MUL_P_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= texmip_pkg::MUL_P_W'(a) * texmip_pkg::MUL_P_W'(b);
   end

   assign p = p_ff;

endmodule

// ===== sv/texture_mip_layout_calculator.sv =====
// Texture mip layout calculator.
// Configuration: csr_wr_en/csr_index/csr_wdata write one register per cycle
// (width, height, mip count, format code, layer count); write only while idle.
// Request channel: req_valid/req_stall/req_data carries a word with the layer
// and mip level. Response channel: rsp_valid/rsp_stall/rsp_data returns one
// word per request: valid flag, byte offset, level size and whole image size.
// A request is taken only while the block is idle; req_stall is high during
// the computation. One shared multiplier walks the level chain, a MULA and a
// MULB state per level, over the larger of the mip count and level+1 levels;
// the LAST, LAYER, TOTAL and FIN states then lead to the response word.
// The response sits in an output register; a new request is accepted while
// it waits, and a finished computation holds until that register is free.
// When the receiver stalls, rsp_data holds steady. Synchronous reset clears
// the sequencer and the response valid and loads the registers' reset values.
module texture_mip_layout_calculator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [texmip_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [texmip_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  texmip_pkg::req_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output texmip_pkg::rsp_type                rsp_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MULA  = 3'd1;
   localparam logic [2:0] S_MULB  = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_LAYER = 3'd4;
   localparam logic [2:0] S_TOTAL = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   localparam int PW = texmip_pkg::MUL_P_W;

   texmip_pkg::cfg_type cfg;

   logic [texmip_pkg::MUL_A_W-1:0] mul_a;
   logic [texmip_pkg::MUL_B_W-1:0] mul_b;
   logic [PW-1:0]                  mul_p;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  idx_ff, idx_in;
   logic [4:0]  last_ff, last_in;
   logic        acc_ff, acc_in;
   logic [4:0]  acc_lvl_ff, acc_lvl_in;
   logic [14:0] w_ff, w_in;
   logic [14:0] h_ff, h_in;
   logic [10:0] layer_ff, layer_in;
   logic [3:0]  level_ff, level_in;
   logic        valid_ff, valid_in;
   logic [35:0] lsize_ff, lsize_in;
   logic [35:0] before_ff, before_in;
   logic [32:0] lbytes_ff, lbytes_in;
   logic [43:0] offset_ff, offset_in;
   logic        rsp_valid_ff, rsp_valid_in;
   texmip_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [14:0] w_dim, h_dim;
   logic [33:0] lvl_size;
   logic [4:0]  req_n;
   logic [PW:0] ofs_sum;
   logic        out_free;

   texmip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   texmip_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // block-compressed levels count 4x4 blocks, rounding up
   assign w_dim = cfg.compressed ? 15'((16'(w_ff) + 16'd3) >> 2) : w_ff;
   assign h_dim = cfg.compressed ? 15'((16'(h_ff) + 16'd3) >> 2) : h_ff;
   assign lvl_size = mul_p[33:0];
   assign req_n = ((5'(req_data.level) + 5'd1) > cfg.mips)
                  ? (5'(req_data.level) + 5'd1) : cfg.mips;
   assign ofs_sum = (PW+1)'(mul_p) + (PW+1)'(before_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      acc_in       = 1'b0;
      acc_lvl_in   = acc_lvl_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      layer_in     = layer_ff;
      level_in     = level_ff;
      valid_in     = valid_ff;
      lsize_in     = lsize_ff;
      before_in    = before_ff;
      lbytes_in    = lbytes_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_a        = texmip_pkg::MUL_A_W'(w_dim);
      mul_b        = texmip_pkg::MUL_B_W'(cfg.unit);

      // fold in the level size finished in the previous cycle
      if (acc_ff) begin
         if (acc_lvl_ff < cfg.mips) begin
            lsize_in = lsize_ff + 36'(lvl_size);
            if (acc_lvl_ff < 5'(level_ff)) begin
               before_in = before_ff + 36'(lvl_size);
            end
         end
         if (acc_lvl_ff == 5'(level_ff)) begin
            lbytes_in = lvl_size[33] ? '1 : lvl_size[32:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               layer_in  = req_data.layer;
               level_in  = req_data.level;
               valid_in  = 5'(req_data.level) < cfg.mips;
               last_in   = req_n - 5'd1;
               idx_in    = 5'd0;
               w_in      = cfg.width;
               h_in      = cfg.height;
               lsize_in  = '0;
               before_in = '0;
               lbytes_in = '0;
               state_in  = S_MULA;
            end
         end
         S_MULA: begin
            state_in = S_MULB;
         end
         S_MULB: begin
            mul_a      = mul_p[texmip_pkg::MUL_A_W-1:0];
            mul_b      = texmip_pkg::MUL_B_W'(h_dim);
            acc_in     = 1'b1;
            acc_lvl_in = idx_ff;
            idx_in     = idx_ff + 5'd1;
            w_in       = w_ff >> 1;
            h_in       = h_ff >> 1;
            state_in   = (idx_ff == last_ff) ? S_LAST : S_MULA;
         end
         S_LAST: begin
            state_in = S_LAYER;
         end
         S_LAYER: begin
            mul_a    = lsize_ff;
            mul_b    = texmip_pkg::MUL_B_W'(layer_ff);
            state_in = S_TOTAL;
         end
         S_TOTAL: begin
            mul_a = lsize_ff;
            mul_b = texmip_pkg::MUL_B_W'(cfg.layers);
            if (!valid_ff) begin
               offset_in = '0;
            end else if (|ofs_sum[PW:44]) begin
               offset_in = '1;
            end else begin
               offset_in = ofs_sum[43:0];
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            // keep the total product steady while the output register is busy
            mul_a = lsize_ff;
            mul_b = texmip_pkg::MUL_B_W'(cfg.layers);
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.level_valid  = valid_ff;
               rsp_data_in.byte_offset  = offset_ff;
               rsp_data_in.level_bytes  = lbytes_ff;
               rsp_data_in.total_bytes  = (|mul_p[PW-1:44]) ? '1 : mul_p[43:0];
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      acc_lvl_ff  <= acc_lvl_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      layer_ff    <= layer_in;
      level_ff    <= level_in;
      valid_ff    <= valid_in;
      lsize_ff    <= lsize_in;
      before_ff   <= before_in;
      lbytes_ff   <= lbytes_in;
      offset_ff   <= offset_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_MULA))
      else $error("accepted request did not start the level walk");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MULB) |-> (idx_ff <= last_ff))
      else $error("level index ran past the last level");

   a_before_le_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LAYER) |-> (before_ff <= lsize_ff))
      else $error("earlier-level sum exceeds layer size");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.level_valid) |-> (rsp_data_ff.byte_offset == 44'd0))
      else $error("invalid level carries a nonzero offset");

   a_word_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && (state_ff != S_FIN)) |=> !rsp_valid_ff)
      else $error("response word repeated after it was taken");
`endif

endmodule

// ===== test/tb.sv =====
module tb;

   localparam int LIMIT_CYCLES   = 1500000;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int TAIL_CYCLES    = 40;

   localparam logic [5:0] FMT_R8       = 6'd0;
   localparam logic [5:0] FMT_RGBA8    = 6'd3;
   localparam logic [5:0] FMT_RGBA32F  = 6'd16;
   localparam logic [5:0] FMT_DXT1     = 6'd25;
   localparam logic [5:0] FMT_BC7      = 6'd29;
   localparam logic [5:0] FMT_UNKNOWN  = 6'd35;
   localparam logic [5:0] FMT_MAX_CODE = 6'd63;

   localparam logic [63:0] LEVEL_BYTES_MAX = (64'd1 << 33) - 64'd1;
   localparam logic [63:0] OFFSET_MAX      = (64'd1 << 44) - 64'd1;

   // bytes per pixel, or per 4x4 block for the compressed codes
   localparam int UNIT_BYTES [36] = '{
      1, 2, 3, 4, 4, 2, 4, 6, 8, 2, 4, 6, 8, 4, 8, 12, 16,
      1, 4, 1, 2, 3, 4, 4, 4,
      8, 16, 16, 16, 16,
      2, 3, 4, 4, 5,
      0
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [texmip_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [texmip_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   texmip_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   texmip_pkg::rsp_type rsp_data;

   logic [14:0] cfg_width;
   logic [14:0] cfg_height;
   logic [3:0]  cfg_mips;
   logic [5:0]  cfg_format;
   logic [11:0] cfg_layers;

   texmip_pkg::rsp_type pending_layouts [$];
   texmip_pkg::rsp_type want_rsp;
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   texture_mip_layout_calculator dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] mip_bytes(input int lvl);
      logic [63:0] w;
      logic [63:0] h;
      if (cfg_format >= 6'd36) return 64'd0;
      w = 64'(cfg_width) >> lvl;
      h = 64'(cfg_height) >> lvl;
      if (cfg_format >= FMT_DXT1 && cfg_format <= FMT_BC7) begin
         w = (w + 64'd3) / 64'd4;
         h = (h + 64'd3) / 64'd4;
      end
      return w * h * 64'(UNIT_BYTES[cfg_format]);
   endfunction

   function automatic texmip_pkg::rsp_type predict_layout(input texmip_pkg::req_type r);
      texmip_pkg::rsp_type e;
      int mips;
      logic [63:0] layers;
      logic [63:0] layer_size;
      logic [63:0] earlier;
      logic [63:0] sum;
      logic [63:0] lb;
      mips = (cfg_mips > texmip_pkg::MAX_LEVELS) ? texmip_pkg::MAX_LEVELS : int'(cfg_mips);
      layers = (cfg_layers > texmip_pkg::MAX_LAYERS)
               ? 64'(texmip_pkg::MAX_LAYERS) : 64'(cfg_layers);
      layer_size = 64'd0;
      earlier = 64'd0;
      for (int i = 0; i < mips; i++) begin
         if (i < int'(r.level)) earlier += mip_bytes(i);
         layer_size += mip_bytes(i);
      end
      e.level_valid = int'(r.level) < mips;
      sum = layer_size * layers;
      e.total_bytes = (sum > OFFSET_MAX) ? OFFSET_MAX[43:0] : sum[43:0];
      sum = 64'(r.layer) * layer_size + earlier;
      if (!e.level_valid) e.byte_offset = '0;
      else e.byte_offset = (sum > OFFSET_MAX) ? OFFSET_MAX[43:0] : sum[43:0];
      lb = mip_bytes(int'(r.level));
      e.level_bytes = (lb > LEVEL_BYTES_MAX) ? LEVEL_BYTES_MAX[32:0] : lb[32:0];
      return e;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_layouts.size() == 0) begin
            $display("%0t: unexpected response word, expected none actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want_rsp = pending_layouts.pop_front();
            report_field("level_valid", 64'(want_rsp.level_valid), 64'(rsp_data.level_valid));
            report_field("byte_offset", 64'(want_rsp.byte_offset), 64'(rsp_data.byte_offset));
            report_field("level_bytes", 64'(want_rsp.level_bytes), 64'(rsp_data.level_bytes));
            report_field("total_bytes", 64'(want_rsp.total_bytes), 64'(rsp_data.total_bytes));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // valid stays high into the next word when there is no gap
   task automatic send_request(input int layer, input int level);
      texmip_pkg::req_type w;
      int gap;
      w.layer = 11'(layer);
      w.level = 4'(level);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      pending_layouts.push_back(predict_layout(w));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_layouts.size() != 0);
   endtask

   task automatic write_reg(input logic [texmip_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= texmip_pkg::CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic set_layout(input int w, input int h, input int m, input int f, input int l);
      wait_drain();
      write_reg(texmip_pkg::REG_IMAGE_WIDTH, w);
      write_reg(texmip_pkg::REG_IMAGE_HEIGHT, h);
      write_reg(texmip_pkg::REG_MIP_COUNT, m);
      write_reg(texmip_pkg::REG_FORMAT_CODE, f);
      write_reg(texmip_pkg::REG_LAYER_COUNT, l);
      csr_wr_en <= 1'b0;
      cfg_width = 15'(w);
      cfg_height = 15'(h);
      cfg_mips = 4'(m);
      cfg_format = 6'(f);
      cfg_layers = 12'(l);
   endtask

   task automatic test_reset_defaults();
      send_request(0, 0);
      send_request(2047, 0);
      send_request(5, 1);
      send_request(0, 15);
   endtask

   task automatic test_extremes();
      set_layout(32767, 32767, 15, FMT_RGBA32F, 4095);
      send_request(2047, 0);
      send_request(0, 1);
      send_request(2047, 14);
      send_request(1, 15);
      set_layout(16384, 16384, 15, FMT_RGBA32F, 2048);
      send_request(2047, 14);
      send_request(3, 0);
   endtask

   task automatic test_compressed();
      set_layout(13, 7, 15, FMT_DXT1, 6);
      send_request(0, 0);
      send_request(1, 2);
      send_request(9, 3);
      send_request(2, 14);
      set_layout(1, 16384, 15, FMT_BC7, 2048);
      send_request(2047, 0);
      send_request(7, 14);
   endtask

   task automatic test_unknown_format();
      set_layout(64, 64, 4, FMT_UNKNOWN, 3);
      send_request(1, 0);
      send_request(2, 3);
      set_layout(64, 64, 0, FMT_MAX_CODE, 0);
      send_request(0, 0);
      send_request(5, 15);
   endtask

   task automatic test_small_base();
      set_layout(1, 16384, 15, FMT_R8, 2049);
      send_request(2047, 14);
      send_request(0, 1);
      set_layout(0, 100, 3, FMT_RGBA8, 1);
      send_request(0, 2);
   endtask

   function automatic int rand_dim();
      case ($urandom_range(0, 9))
         0: return 1;
         1: return 16384;
         2: return 32767;
         3: return 0;
         4, 5, 6: return $urandom_range(1, 64);
         7, 8: return $urandom_range(1, 2048);
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   task automatic test_random();
      int sent;
      int burst;
      int fmt;
      int lay;
      int mips;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: fmt = $urandom_range(FMT_DXT1, FMT_BC7);
            3: fmt = $urandom_range(FMT_UNKNOWN, FMT_MAX_CODE);
            default: fmt = $urandom_range(0, FMT_UNKNOWN);
         endcase
         case ($urandom_range(0, 7))
            0: lay = 0;
            1: lay = 4095;
            2: lay = 2048;
            3: lay = 2049;
            4: lay = $urandom_range(0, 4095);
            default: lay = $urandom_range(1, 16);
         endcase
         mips = $urandom_range(0, 15);
         set_layout(rand_dim(), rand_dim(), mips, fmt, lay);
         quiet = ($urandom_range(0, 4) == 0);
         burst = $urandom_range(10, 60);
         repeat (burst) begin
            if (mips > 0 && $urandom_range(0, 9) < 7)
               send_request($urandom_range(0, 2047), $urandom_range(0, mips - 1));
            else
               send_request($urandom_range(0, 2047), $urandom_range(0, 15));
         end
         quiet = 1'b0;
         sent += burst;
      end
   endtask

   initial begin
      cfg_width = 15'd1;
      cfg_height = 15'd1;
      cfg_mips = 4'd1;
      cfg_format = FMT_RGBA8;
      cfg_layers = 12'd1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extremes();
      test_compressed();
      test_unknown_format();
      test_small_base();
      test_random();
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_layouts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
